// File: rtl/leb_triangle_from_heap_id_top_macros.svh
// assertion macros used by the top rtl file
`ifndef LEB_TRIANGLE_FROM_HEAP_ID_TOP_MACROS_SVH
`define LEB_TRIANGLE_FROM_HEAP_ID_TOP_MACROS_SVH

// checked on every clock edge outside reset
`define LEB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define LEB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// File: rtl/lebtri_pkg.sv
// types, constants and fixed-point helpers of the triangle decoder
`timescale 1ns / 1ps

package lebtri_pkg;

    localparam int ID_W           = 64;
    localparam int PORT_COORD_W   = 32;
    localparam int COORD_WIDTH    = 32;
    localparam int BASE_BISECTORS = 4;
    localparam int NPOINTS        = 3 * BASE_BISECTORS;
    localparam int ADDR_W         = (NPOINTS > 1) ? $clog2(NPOINTS) : 1;
    localparam int BASE_W         = (BASE_BISECTORS > 1) ? $clog2(BASE_BISECTORS) : 1;
    localparam int DEPTH_W        = $clog2(ID_W + 1);
    localparam int SUB_W          = $clog2(ID_W);
    localparam int CFG_W          = 6;
    localparam int BYTE_W         = 8;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t u;
        coord_t h;
        coord_t v;
    } point_t;

    // status of the bit-length unit
    typedef struct packed {
        logic               done;
        logic [DEPTH_W-1:0] depth;
    } len_status_t;

    function automatic coord_t to_coord(logic signed [PORT_COORD_W-1:0] x);
        logic signed [63:0] w;
        w = 64'(x);
        return w[COORD_WIDTH-1:0];
    endfunction

    function automatic logic [PORT_COORD_W-1:0] from_coord(coord_t c);
        logic signed [63:0] w;
        w = 64'(c);
        return w[PORT_COORD_W-1:0];
    endfunction

    // floor of the average, exact sum one bit wider
    function automatic coord_t half_sum(coord_t a, coord_t b);
        logic signed [COORD_WIDTH:0] s;
        s = {a[COORD_WIDTH-1], a} + {b[COORD_WIDTH-1], b};
        return s[COORD_WIDTH:1];
    endfunction

    function automatic point_t mid_point(point_t a, point_t b);
        point_t m;
        m.u = half_sum(a.u, b.u);
        m.h = half_sum(a.h, b.h);
        m.v = half_sum(a.v, b.v);
        return m;
    endfunction

endpackage

// File: rtl/leb_triangle_from_heap_id_top.sv
// Longest-edge-bisection triangle decoder. A load transaction (s_tuser 0) writes one
// control point into a 12-entry table. An evaluate transaction (s_tuser 1) finds the
// bit length of the heap id (one byte per cycle), decodes the base bisector, fetches
// the three base control points from the table through its single registered read
// port, then splits the triangle once per path bit on one shared midpoint unit plus
// one closing step, and then places the first result in the output register. Results
// then leave at one per cycle while m_tready allows: six results (child vertices then
// parent vertices) or one invalid result, tlast on the final one. The next transaction
// is taken as soon as the final result sits in the output register. Table entries
// that were never written read back undefined; there is no clearing pass.
`timescale 1ns / 1ps
`include "leb_triangle_from_heap_id_top_macros.svh"

module leb_triangle_from_heap_id_top import lebtri_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    // configuration: base_depth
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    // input stream
    input  logic             s_tvalid,
    output logic             s_tready,
    // heap_id[63:0], point_index[67:64], point_u[99:68], point_height[131:100],
    // point_v[163:132], zero pad
    input  logic [167:0]     s_tdata,
    // action[0]
    input  logic             s_tuser,
    // result stream
    output logic             m_tvalid,
    input  logic             m_tready,
    // valid_res[0], base_bisector[2:1], vertex[4:3], vertex_u[36:5],
    // vertex_height[68:37], vertex_v[100:69], zero pad
    output logic [103:0]     m_tdata,
    // which_triangle[0]
    output logic             m_tuser,
    output logic             m_tlast
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LEN   = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_FETCH = 3'd4;
    localparam logic [2:0] S_SPLIT = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    localparam logic       ACT_LOAD = 1'b0;
    localparam logic [1:0] VTX_LAST = 2'd2;

    // input fields
    logic [ID_W-1:0]         in_heap_id;
    logic [3:0]              in_point_index;
    logic [PORT_COORD_W-1:0] in_u, in_h, in_v;

    assign in_heap_id     = s_tdata[63:0];
    assign in_point_index = s_tdata[67:64];
    assign in_u           = s_tdata[99:68];
    assign in_h           = s_tdata[131:100];
    assign in_v           = s_tdata[163:132];

    logic [CFG_W-1:0] base_depth_reg;

    logic [2:0]        state_reg, state_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [SUB_W-1:0]  sub_reg, sub_next;
    logic [ID_W-1:0]   base_id_reg, base_id_next;
    logic [BASE_W-1:0] base_reg, base_next;
    logic              invalid_reg, invalid_next;
    logic [1:0]        fetch_cnt_reg, fetch_cnt_next;
    logic [1:0]        vtx_reg, vtx_next;
    logic              which_reg, which_next;
    point_t            child_reg [3];
    point_t            child_next [3];
    point_t            parent_reg [3];
    point_t            parent_next [3];

    // output register
    logic                    m_valid_reg, m_valid_next;
    logic                    o_valid_res_reg, o_valid_res_next;
    logic [1:0]              o_base_reg, o_base_next;
    logic                    o_which_reg, o_which_next;
    logic [1:0]              o_vertex_reg, o_vertex_next;
    logic [PORT_COORD_W-1:0] o_u_reg, o_u_next;
    logic [PORT_COORD_W-1:0] o_h_reg, o_h_next;
    logic [PORT_COORD_W-1:0] o_v_reg, o_v_next;
    logic                    o_last_reg, o_last_next;

    // control point table
    point_t            cp_mem [NPOINTS];
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    point_t            wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    point_t            rd_data_reg;

    logic        len_start;
    len_status_t len_status;

    logic                in_acc;
    logic                out_free;
    logic [DEPTH_W-1:0]  depth_sub;
    logic [ID_W-1:0]     first_id;
    logic [ID_W-1:0]     base_diff;
    point_t              split_mid;
    logic                split_right;
    point_t              emit_pt;

    lebtri_bitlen u_bitlen (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (len_start),
        .id      (in_heap_id),
        .status  (len_status)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign depth_sub   = len_status.depth - DEPTH_W'(base_depth_reg);
    assign first_id    = ID_W'(1) << (base_depth_reg - CFG_W'(1));
    assign base_diff   = base_id_reg - first_id;
    assign split_mid   = mid_point(child_reg[0], child_reg[2]);
    assign split_right = id_reg[sub_reg - SUB_W'(1)];
    assign emit_pt     = which_reg ? parent_reg[vtx_reg] : child_reg[vtx_reg];

    assign wr_en   = in_acc && (s_tuser == ACT_LOAD) && (32'(in_point_index) < NPOINTS);
    assign wr_addr = ADDR_W'(in_point_index);
    assign wr_data = '{u: to_coord(in_u), h: to_coord(in_h), v: to_coord(in_v)};

    always_comb begin
        state_next       = state_reg;
        id_next          = id_reg;
        sub_next         = sub_reg;
        base_id_next     = base_id_reg;
        base_next        = base_reg;
        invalid_next     = invalid_reg;
        fetch_cnt_next   = fetch_cnt_reg;
        vtx_next         = vtx_reg;
        which_next       = which_reg;
        child_next       = child_reg;
        parent_next      = parent_reg;
        len_start        = 1'b0;
        rd_en            = 1'b0;
        rd_addr          = '0;
        m_valid_next     = m_valid_reg && !m_tready;
        o_valid_res_next = o_valid_res_reg;
        o_base_next      = o_base_reg;
        o_which_next     = o_which_reg;
        o_vertex_next    = o_vertex_reg;
        o_u_next         = o_u_reg;
        o_h_next         = o_h_reg;
        o_v_next         = o_v_reg;
        o_last_next      = o_last_reg;

        case (state_reg)
            S_IDLE: begin
                if (in_acc && (s_tuser != ACT_LOAD)) begin
                    id_next    = in_heap_id;
                    len_start  = 1'b1;
                    state_next = S_LEN;
                end
            end
            S_LEN: begin
                if (len_status.done) begin
                    vtx_next   = '0;
                    which_next = 1'b0;
                    sub_next   = depth_sub[SUB_W-1:0];
                    if (len_status.depth == '0 || base_depth_reg == '0 ||
                        len_status.depth < DEPTH_W'(base_depth_reg)) begin
                        invalid_next = 1'b1;
                        state_next   = S_EMIT;
                    end else begin
                        invalid_next = 1'b0;
                        state_next   = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                base_id_next = id_reg >> sub_reg;
                state_next   = S_CHECK;
            end
            S_CHECK: begin
                if (base_diff >= ID_W'(BASE_BISECTORS)) begin
                    invalid_next = 1'b1;
                    state_next   = S_EMIT;
                end else begin
                    base_next      = base_diff[BASE_W-1:0];
                    rd_en          = 1'b1;
                    rd_addr        = ADDR_W'(32'(base_diff[BASE_W-1:0]) * 3);
                    fetch_cnt_next = '0;
                    state_next     = S_FETCH;
                end
            end
            S_FETCH: begin
                child_next[fetch_cnt_reg]  = rd_data_reg;
                parent_next[fetch_cnt_reg] = rd_data_reg;
                if (fetch_cnt_reg == VTX_LAST) begin
                    state_next = S_SPLIT;
                end else begin
                    rd_en          = 1'b1;
                    rd_addr        = ADDR_W'(32'(base_reg) * 3 + 32'(fetch_cnt_reg) + 1);
                    fetch_cnt_next = fetch_cnt_reg + 2'd1;
                end
            end
            S_SPLIT: begin
                if (sub_reg == '0) begin
                    state_next = S_EMIT;
                end else begin
                    parent_next = child_reg;
                    if (split_right) begin
                        child_next[0] = child_reg[1];
                        child_next[2] = child_reg[0];
                    end else begin
                        child_next[0] = child_reg[2];
                        child_next[2] = child_reg[1];
                    end
                    child_next[1] = split_mid;
                    sub_next      = sub_reg - SUB_W'(1);
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (invalid_reg) begin
                        o_valid_res_next = 1'b0;
                        o_base_next      = '0;
                        o_which_next     = 1'b0;
                        o_vertex_next    = '0;
                        o_u_next         = '0;
                        o_h_next         = '0;
                        o_v_next         = '0;
                        o_last_next      = 1'b1;
                        state_next       = S_IDLE;
                    end else begin
                        o_valid_res_next = 1'b1;
                        o_base_next      = 2'(base_reg);
                        o_which_next     = which_reg;
                        o_vertex_next    = vtx_reg;
                        o_u_next         = from_coord(emit_pt.u);
                        o_h_next         = from_coord(emit_pt.h);
                        o_v_next         = from_coord(emit_pt.v);
                        o_last_next      = which_reg && (vtx_reg == VTX_LAST);
                        if (vtx_reg == VTX_LAST) begin
                            vtx_next   = '0;
                            which_next = 1'b1;
                            if (which_reg) begin
                                state_next = S_IDLE;
                            end
                        end else begin
                            vtx_next = vtx_reg + 2'd1;
                        end
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            base_depth_reg <= CFG_W'(1);
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                base_depth_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        id_reg          <= id_next;
        sub_reg         <= sub_next;
        base_id_reg     <= base_id_next;
        base_reg        <= base_next;
        invalid_reg     <= invalid_next;
        fetch_cnt_reg   <= fetch_cnt_next;
        vtx_reg         <= vtx_next;
        which_reg       <= which_next;
        child_reg       <= child_next;
        parent_reg      <= parent_next;
        o_valid_res_reg <= o_valid_res_next;
        o_base_reg      <= o_base_next;
        o_which_reg     <= o_which_next;
        o_vertex_reg    <= o_vertex_next;
        o_u_reg         <= o_u_next;
        o_h_reg         <= o_h_next;
        o_v_reg         <= o_v_next;
        o_last_reg      <= o_last_next;
    end

    // control point table, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            cp_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= cp_mem[rd_addr];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, o_v_reg, o_h_reg, o_u_reg, o_vertex_reg, o_base_reg,
                       o_valid_res_reg};
    assign m_tuser  = o_which_reg;
    assign m_tlast  = o_last_reg;

    logic split_busy;
    logic last_valid_out;
    logic last_vtx_ok;

    assign split_busy     = (state_reg == S_SPLIT) && (sub_reg != '0);
    assign last_valid_out = m_tvalid && m_tlast && m_tdata[0];
    assign last_vtx_ok    = m_tuser && (m_tdata[4:3] == VTX_LAST);

    `LEB_ASSERT(a_len_done, len_status.done |-> (state_reg == S_LEN), "length done outside wait")
    `LEB_ASSERT(a_split_walk, split_busy |=> (state_reg == S_SPLIT), "split walk left early")
    `LEB_ASSERT(a_invalid_last, (m_tvalid && !m_tdata[0]) |-> m_tlast, "invalid result not last")
    `LEB_ASSERT(a_last_parent, last_valid_out |-> last_vtx_ok, "final result not parent vertex 2")

endmodule

// File: rtl/lebtri_bitlen.sv
// iterative bit-length unit for the 64-bit heap id, one byte per cycle
`timescale 1ns / 1ps

module lebtri_bitlen import lebtri_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [ID_W-1:0] id,
    output len_status_t     status
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [ID_W-1:0]    word_reg, word_next;
    logic [DEPTH_W-1:0] cnt_reg, cnt_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [BYTE_W-1:0]  top_byte;
    logic [3:0]         lz;

    function automatic logic [3:0] lzc8(logic [BYTE_W-1:0] b);
        logic [3:0] n;
        logic       hit;
        n   = 4'd0;
        hit = 1'b0;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            if (b[i]) begin
                hit = 1'b1;
            end else if (!hit) begin
                n = n + 4'd1;
            end
        end
        return n;
    endfunction

    assign top_byte = word_reg[ID_W-1 -: BYTE_W];
    assign lz       = lzc8(top_byte);

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        word_next  = word_reg;
        cnt_next   = cnt_reg;
        depth_next = depth_reg;
        if (start) begin
            busy_next = 1'b1;
            word_next = id;
            cnt_next  = DEPTH_W'(ID_W);
        end else if (busy_reg) begin
            if (top_byte != '0) begin
                depth_next = cnt_reg - DEPTH_W'(lz);
                done_next  = 1'b1;
                busy_next  = 1'b0;
            end else if (cnt_reg == DEPTH_W'(BYTE_W)) begin
                // all bytes zero
                depth_next = '0;
                done_next  = 1'b1;
                busy_next  = 1'b0;
            end else begin
                word_next = word_reg << BYTE_W;
                cnt_next  = cnt_reg - DEPTH_W'(BYTE_W);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg  <= word_next;
        cnt_reg   <= cnt_next;
        depth_reg <= depth_next;
    end

    assign status.done  = done_reg;
    assign status.depth = depth_reg;

endmodule
